### src/swmc_pkg.sv
// Shared types and constants of the sliding-window median cost block.
package swmc_pkg;

	localparam int COST_BITS = 36;
	localparam int WSIZE_BITS = 7;
	localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 7'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_LOAD_MED,
		ST_SCAN_MED,
		ST_LOAD_SUM,
		ST_SCAN_SUM,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic accept;
		logic remove;
		logic insert;
		logic load_med;
		logic scan_med;
		logic load_sum;
		logic scan_sum;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic item_full;
		logic emit;
		logic med_hit;
		logic sum_last;
		logic out_free;
	} status_t;

endpackage

### src/swmc_if.sv
// Stream interfaces for the sample channel and the cost channel.
interface swmc_in_if #(parameter int SAMPLE_BITS = 30);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   start_req;

	modport source (output valid, output sample, output start_req, input ready);
	modport sink (input valid, input sample, input start_req, output ready);
endinterface

interface swmc_out_if;
	logic                            valid;
	logic                            ready;
	logic [swmc_pkg::COST_BITS-1:0]  cost;

	modport source (output valid, output cost, input ready);
	modport sink (input valid, input cost, output ready);
endinterface

### src/swmc_ctrl.sv
// Sequencer of the sliding-window median cost block.
module swmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  swmc_pkg::status_t status,
	output swmc_pkg::cmd_t    cmd
);

	swmc_pkg::state_t state_q, state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swmc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swmc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = status.item_full ? swmc_pkg::ST_REMOVE : swmc_pkg::ST_INSERT;
				end
			end
			swmc_pkg::ST_REMOVE:   state_d = swmc_pkg::ST_INSERT;
			swmc_pkg::ST_INSERT:   state_d = status.emit ? swmc_pkg::ST_LOAD_MED : swmc_pkg::ST_IDLE;
			swmc_pkg::ST_LOAD_MED: state_d = swmc_pkg::ST_SCAN_MED;
			swmc_pkg::ST_SCAN_MED: begin
				if (status.med_hit) state_d = swmc_pkg::ST_LOAD_SUM;
			end
			swmc_pkg::ST_LOAD_SUM: state_d = swmc_pkg::ST_SCAN_SUM;
			swmc_pkg::ST_SCAN_SUM: begin
				if (status.sum_last) state_d = swmc_pkg::ST_RESULT;
			end
			swmc_pkg::ST_RESULT: begin
				if (status.out_free) state_d = swmc_pkg::ST_IDLE;
			end
			default: state_d = swmc_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			swmc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			swmc_pkg::ST_REMOVE:   cmd.remove = 1'b1;
			swmc_pkg::ST_INSERT:   cmd.insert = 1'b1;
			swmc_pkg::ST_LOAD_MED: cmd.load_med = 1'b1;
			swmc_pkg::ST_SCAN_MED: cmd.scan_med = 1'b1;
			swmc_pkg::ST_LOAD_SUM: cmd.load_sum = 1'b1;
			swmc_pkg::ST_SCAN_SUM: cmd.scan_sum = 1'b1;
			swmc_pkg::ST_RESULT:   cmd.out_load = status.out_free;
			default: ;
		endcase
	end

endmodule

### src/swmc_dp.sv
// Datapath: sample store, sorted cell chain, median scan and cost accumulator.
module swmc_dp #(
	parameter int MAX_WINDOW = 64,
	parameter int SAMPLE_BITS = 30
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [swmc_pkg::WSIZE_BITS-1:0]  cfg_wdata,
	input  logic [SAMPLE_BITS-1:0]           sample,
	input  logic                             start_req,
	input  swmc_pkg::cmd_t                   cmd,
	output swmc_pkg::status_t                status,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [swmc_pkg::COST_BITS-1:0]   cost
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int CB = swmc_pkg::COST_BITS;

	logic [swmc_pkg::WSIZE_BITS-1:0] ws_q;
	logic [CW-1:0]          seen_q, ins_cnt_q, k_w, seen_n, seen_inc;
	logic [AW-1:0]          head_q, head_n, step_q, m_w, mem_addr;
	logic [CW-1:0]          head_inc;
	logic                   full_n, emit_q;
	logic [SAMPLE_BITS-1:0] v_q, old_q, med_q;
	logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] cells_q [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] cells_d [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] scan_q [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]  eq_v, gt_v, low_v, rm_v;
	logic [SAMPLE_BITS-1:0] dev;
	logic [CB-1:0]          acc_q, cost_q;
	logic                   out_valid_q;

	// Effective window size and median index
	always_comb begin
		if (ws_q == '0) begin
			k_w = CW'(1);
		end else if (int'(ws_q) > MAX_WINDOW) begin
			k_w = CW'(MAX_WINDOW);
		end else begin
			k_w = CW'(ws_q);
		end
		m_w = AW'((k_w - CW'(1)) >> 1);
	end

	// Fix up the counters of the offered item
	always_comb begin
		seen_n = start_req ? '0 : seen_q;
		if (seen_n > k_w) seen_n = '0;
		head_n = start_req ? '0 : head_q;
		if (CW'(head_n) >= k_w) head_n = '0;
		full_n = (seen_n >= k_w);
		seen_inc = seen_n + CW'(1);
		head_inc = CW'(head_n) + CW'(1);
		mem_addr = full_n ? head_n : seen_n[AW-1:0];
	end

	// Sample store in arrival order, read before write
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			old_q <= mem[mem_addr];
			mem[mem_addr] <= sample;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= swmc_pkg::WSIZE_RESET;
			seen_q <= '0;
			head_q <= '0;
			emit_q <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ws_q <= cfg_wdata;
				seen_q <= '0;
				head_q <= '0;
			end else if (cmd.accept) begin
				emit_q <= full_n || (seen_inc == k_w);
				if (full_n) begin
					head_q <= (head_inc == k_w) ? '0 : head_inc[AW-1:0];
				end else begin
					seen_q <= seen_inc;
					head_q <= head_n;
				end
			end
			if (cmd.load_med || cmd.load_sum) begin
				step_q <= '0;
			end else if ((cmd.scan_med && !status.med_hit) || cmd.scan_sum) begin
				step_q <= step_q + AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the item payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q <= sample;
			ins_cnt_q <= full_n ? (k_w - CW'(1)) : seen_n;
		end
	end

	// Compare vectors across the sorted cells
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			eq_v[i] = (cells_q[i] == old_q) && (CW'(i) < k_w);
			gt_v[i] = (cells_q[i] > v_q) && (CW'(i) < ins_cnt_q);
		end
		low_v = eq_v & (~eq_v + MAX_WINDOW'(1));
		rm_v = (low_v == '0) ? '0 : ~(low_v - MAX_WINDOW'(1));
	end

	// Next cell values: drop the oldest sample or insert the new one
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			cells_d[i] = cells_q[i];
			if (cmd.remove) begin
				if (rm_v[i] && (CW'(i + 1) < k_w)) cells_d[i] = cells_q[(i + 1) % MAX_WINDOW];
			end else if (cmd.insert) begin
				if (i > 0 && gt_v[(i + MAX_WINDOW - 1) % MAX_WINDOW]) begin
					cells_d[i] = cells_q[(i + MAX_WINDOW - 1) % MAX_WINDOW];
				end else if (CW'(i) <= ins_cnt_q && (gt_v[i] || CW'(i) == ins_cnt_q)) begin
					cells_d[i] = v_q;
				end
			end
		end
	end

	// Sorted cells and scan chain
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			cells_q[i] <= cells_d[i];
			if (cmd.load_med || cmd.load_sum) begin
				scan_q[i] <= cells_q[i];
			end else if ((cmd.scan_med && !status.med_hit) || cmd.scan_sum) begin
				scan_q[i] <= scan_q[(i + 1) % MAX_WINDOW];
			end
		end
	end

	// Capture the median, accumulate deviations, load the result
	assign dev = (scan_q[0] >= med_q) ? (scan_q[0] - med_q) : (med_q - scan_q[0]);

	always_ff @(posedge clk) begin
		if (cmd.scan_med && status.med_hit) med_q <= scan_q[0];
		if (cmd.load_sum) begin
			acc_q <= '0;
		end else if (cmd.scan_sum) begin
			acc_q <= acc_q + CB'(dev);
		end
		if (cmd.out_load) cost_q <= acc_q;
	end

	assign status.item_full = full_n;
	assign status.emit = emit_q;
	assign status.med_hit = (step_q == m_w);
	assign status.sum_last = (CW'(step_q) == (k_w - CW'(1)));
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign cost = cost_q;

endmodule

### src/sliding_window_median_cost_core.sv
// Top level of the sliding-window median cost block: sum of absolute deviations from the median.
// Usage:
//   in_ch carries one sample per transfer; start_req marks the first sample of a
//   new sequence and empties the window first. Once k samples of the sequence
//   are held, each transfer yields one cost on out_ch: the sum of absolute
//   deviations from the lower median (sorted element (k-1)/2).
//   cfg_we/cfg_wdata write the window size k (0 acts as 1, above MAX_WINDOW acts
//   as MAX_WINDOW); a write also empties the window. Write only while idle.
// Timing:
//   One sample is worked at a time. A sample that gives no cost is inserted
//   and the block returns to idle. Once the window is full, each sample first
//   drops the oldest sample from the sorted cell chain, then inserts the new
//   one; the sample that fills the window skips the removal. A shift scan of
//   the cells then finds the median and a second scan adds one deviation per
//   cycle through a single accumulator.
// Reset and stall:
//   Reset empties the window and sets k to 3; stores need no clearing.
//   The cost sits in an output register until taken; if it is still held when
//   the next cost is ready, the block waits and takes no new sample.
module sliding_window_median_cost_core #(
	parameter int MAX_WINDOW = 64,
	parameter int SAMPLE_BITS = 30
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [swmc_pkg::WSIZE_BITS-1:0] cfg_wdata,
	swmc_in_if.sink                         in_ch,
	swmc_out_if.source                      out_ch
);

	swmc_pkg::cmd_t    cmd;
	swmc_pkg::status_t status;

	swmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	swmc_dp #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample    (in_ch.sample),
		.start_req (in_ch.start_req),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cost      (out_ch.cost)
	);

	// One sample in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("sample taken while another is in work");

	// Never overwrite a cost that waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_ch.valid || out_ch.ready))
		else $error("cost overwritten before transfer");

	// Only one datapath operation per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("conflicting datapath commands");

endmodule

### verif/tb_sliding_window_median_cost_core.sv
// Self-checking testbench of the sliding-window median cost block.
`timescale 1ns / 100ps

module tb_sliding_window_median_cost_core;

	localparam int MAXW = 64;
	localparam int SBITS = 30;
	localparam logic [SBITS-1:0] SMAX = '1;
	localparam int SETTLE = 140;

	typedef struct {
		logic [SBITS-1:0] sample;
		logic             start_req;
	} sample_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [swmc_pkg::WSIZE_BITS-1:0] cfg_wdata = '0;

	swmc_in_if #(.SAMPLE_BITS(SBITS)) in_if ();
	swmc_out_if out_if ();

	sliding_window_median_cost_core #(
		.MAX_WINDOW(MAXW),
		.SAMPLE_BITS(SBITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_if),
		.out_ch(out_if)
	);

	sample_item_t pending_samples[$];
	logic [swmc_pkg::COST_BITS-1:0] expected_costs[$];
	int fail_count = 0;
	bit no_idle = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;
	bit in_fire = 1'b0;

	// window model state
	logic [SBITS-1:0] arrival_buf[MAXW];
	logic [SBITS-1:0] sorted_buf[MAXW];
	int held_count = 0;
	int oldest_slot = 0;
	logic [swmc_pkg::WSIZE_BITS-1:0] wsize_reg = swmc_pkg::WSIZE_RESET;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		in_if.valid = 1'b0;
		in_if.sample = '0;
		in_if.start_req = 1'b0;
		out_if.ready = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int active_window();
		if (wsize_reg == 0)
			return 1;
		if (wsize_reg > MAXW)
			return MAXW;
		return int'(wsize_reg);
	endfunction

	function automatic void sorted_insert(int cnt, logic [SBITS-1:0] v);
		int i;
		i = cnt;
		while (i > 0 && sorted_buf[i-1] > v) begin
			sorted_buf[i] = sorted_buf[i-1];
			i--;
		end
		sorted_buf[i] = v;
	endfunction

	function automatic void sorted_drop(int cnt, logic [SBITS-1:0] v);
		int i;
		i = 0;
		while (i < cnt && sorted_buf[i] != v)
			i++;
		for (; i + 1 < cnt; i++)
			sorted_buf[i] = sorted_buf[i+1];
	endfunction

	// Advance the window by one sample; return 1 with the cost once full.
	function automatic bit window_cost_step(input sample_item_t it,
			output logic [swmc_pkg::COST_BITS-1:0] cost);
		int k;
		logic [63:0] acc;
		logic [SBITS-1:0] med;
		logic [SBITS-1:0] old;
		k = active_window();
		cost = '0;
		if (it.start_req) begin
			held_count = 0;
			oldest_slot = 0;
		end
		if (held_count < k) begin
			arrival_buf[held_count] = it.sample;
			sorted_insert(held_count, it.sample);
			held_count++;
			if (held_count < k)
				return 1'b0;
		end else begin
			old = arrival_buf[oldest_slot];
			sorted_drop(k, old);
			sorted_insert(k - 1, it.sample);
			arrival_buf[oldest_slot] = it.sample;
			oldest_slot++;
			if (oldest_slot >= k)
				oldest_slot = 0;
		end
		med = sorted_buf[(k - 1) / 2];
		acc = 0;
		for (int i = 0; i < k; i++)
			acc += (sorted_buf[i] >= med) ? 64'(sorted_buf[i] - med) : 64'(med - sorted_buf[i]);
		cost = acc[swmc_pkg::COST_BITS-1:0];
		return 1'b1;
	endfunction

	// Note each sample transfer for the driver.
	always @(posedge clk) begin
		in_fire <= in_if.valid && in_if.ready;
	end

	// Drive the sample channel at the falling edge.
	always @(negedge clk) begin
		if (arst_n && (!in_if.valid || in_fire)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_if.valid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 9);
				in_if.valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				in_if.sample <= pending_samples[0].sample;
				in_if.start_req <= pending_samples[0].start_req;
				void'(pending_samples.pop_front());
				in_if.valid <= 1'b1;
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// Stall the cost channel in bursts.
	always @(negedge clk) begin
		if (recv_stall > 0) begin
			recv_stall <= recv_stall - 1;
			out_if.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			recv_stall <= $urandom_range(0, 9);
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	// Check each cost transfer, then predict from each sample transfer.
	always @(posedge clk) begin
		sample_item_t it;
		logic [swmc_pkg::COST_BITS-1:0] c;
		if (out_if.valid && out_if.ready) begin
			if (expected_costs.size() == 0) begin
				$display("%0t: unexpected cost, expected none, actual %0d", $time, out_if.cost);
				fail_count++;
			end else begin
				c = expected_costs.pop_front();
				if (out_if.cost !== c) begin
					$display("%0t: cost mismatch, expected %0d, actual %0d", $time, c, out_if.cost);
					fail_count++;
				end
			end
		end
		if (in_if.valid && in_if.ready) begin
			it.sample = in_if.sample;
			it.start_req = in_if.start_req;
			if (window_cost_step(it, c))
				expected_costs = {expected_costs, c};
		end
	end

	task automatic queue_sample(logic [SBITS-1:0] s, logic st);
		sample_item_t it;
		it.sample = s;
		it.start_req = st;
		pending_samples = {pending_samples, it};
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || in_if.valid || expected_costs.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_wsize(logic [swmc_pkg::WSIZE_BITS-1:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		wsize_reg = v;
		held_count = 0;
		oldest_slot = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly long sequences; duplicates and extremes mixed in.
	task automatic queue_random(int n);
		int mode;
		logic [SBITS-1:0] s;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 9);
			if (mode <= 5)
				s = SBITS'($urandom());
			else if (mode <= 8)
				s = SBITS'($urandom_range(0, 7));
			else
				s = $urandom_range(0, 1) ? SMAX : '0;
			queue_sample(s, ($urandom_range(0, 99) < 3) || i == 0);
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset window of three, extremes, duplicates, restarts
		queue_sample('0, 1'b0);
		queue_sample(SMAX, 1'b0);
		queue_sample('0, 1'b0);
		queue_sample(SMAX, 1'b0);
		queue_sample(SMAX, 1'b0);
		queue_sample(SMAX, 1'b0);
		queue_sample(30'd5, 1'b1);
		queue_sample(30'd7, 1'b0);
		queue_sample(30'd7, 1'b1);
		queue_sample(30'd7, 1'b0);
		queue_sample(30'd7, 1'b0);
		queue_sample(30'd7, 1'b0);
		queue_sample(30'd3, 1'b0);
		queue_sample(30'd9, 1'b0);
		queue_sample(30'd1, 1'b1);
		queue_sample(30'd2, 1'b0);
		queue_sample(30'd1, 1'b1);
		queue_sample(SMAX, 1'b0);
		queue_sample('0, 1'b0);
		queue_sample(30'h2AAAAAAA, 1'b0);
		queue_sample(30'h15555555, 1'b0);
		write_wsize(7'd1);
		queue_sample(SMAX, 1'b0);
		queue_sample('0, 1'b1);
		write_wsize(7'd2);
		queue_sample('0, 1'b0);
		queue_sample(SMAX, 1'b0);

		queue_random(150);
		write_wsize(7'd1);
		queue_random(100);
		write_wsize(7'd64);
		queue_random(80);
		write_wsize(7'd0);
		queue_random(60);
		write_wsize(7'd127);
		queue_random(40);
		write_wsize(7'd5);
		queue_random(200);
		write_wsize(7'd100);
		queue_random(20);
		for (int p = 0; p < 5; p++) begin
			write_wsize(swmc_pkg::WSIZE_BITS'($urandom_range(1, 12)));
			queue_random(100);
		end
		write_wsize(7'd4);
		no_idle = 1'b1;
		queue_random(250);

		drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
